// ===== hdl/crc16cfr_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// CRC-16 checked frame receiver package
// Word types, frame layout constants and the reflected CRC-16 byte update.
// ============================================================================
package crc16cfr_pkg;

    localparam int unsigned PAYLOAD_LEN = 18;

    localparam logic [4:0] POS_HEADER0   = 5'd0;
    localparam logic [4:0] POS_PAYLOAD0  = 5'd2;
    localparam logic [4:0] POS_CRC_LOW   = 5'd20;
    localparam logic [4:0] POS_CRC_HIGH  = 5'd21;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef logic [PAYLOAD_LEN-1:0][7:0] t_payload;

    // Power-up accepted payload: all zero except the motion and mine selectors.
    localparam t_payload ACC_RESET = {8'd0, 8'd1, 8'd1, {15{8'd0}}};

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in_word;

    typedef struct packed {
        logic               frame_ok;
        logic [7:0]         left_switch;
        logic [7:0]         right_switch;
        logic signed [15:0] left_stick_x;
        logic signed [15:0] left_stick_y;
        logic signed [15:0] right_stick_x;
        logic signed [15:0] right_stick_y;
        logic [7:0]         zero_force_flag;
        logic [31:0]        angle_bits;
        logic [7:0]         motion_select;
        logic [7:0]         mine_select;
        logic [7:0]         pose_select;
    } t_out_word;

    // One finished frame as handed from the front to the back.
    typedef struct packed {
        logic     ok;
        t_payload payload;
    } t_frame_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'd0, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ===== hdl/crc16cfr_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// CRC-16 checked frame receiver front end
// Tracks the byte position, runs the CRC, captures payload, emits frames.
// ============================================================================
module crc16cfr_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  crc16cfr_pkg::t_in_word  i_word,
    output logic                    o_rec_push,
    output crc16cfr_pkg::t_frame_rec o_rec
);
    import crc16cfr_pkg::*;

    logic [4:0]  r_pos, n_pos, pos;
    logic [15:0] r_crc, n_crc;
    t_payload    r_pend;
    logic [7:0]  r_crc_low;
    logic [15:0] rx_crc;

    always_comb begin
        pos = i_word.frame_start ? POS_HEADER0 : r_pos;
        if (pos > POS_CRC_HIGH) begin
            pos = POS_HEADER0;
        end
        n_pos  = (pos == POS_CRC_HIGH) ? POS_HEADER0 : pos + 5'd1;
        n_crc  = r_crc;
        if (pos == POS_HEADER0) begin
            n_crc = CRC_INIT;
        end else if (pos >= POS_PAYLOAD0 && pos < POS_CRC_LOW) begin
            n_crc = crc_byte(r_crc, i_word.rx_byte);
        end
        rx_crc      = {i_word.rx_byte, r_crc_low};
        o_rec_push  = i_accept && (pos == POS_CRC_HIGH);
        o_rec.ok      = (rx_crc == r_crc);
        o_rec.payload = r_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_HEADER0;
            r_crc     <= CRC_INIT;
            r_crc_low <= 8'd0;
        end else if (i_accept) begin
            r_pos <= n_pos;
            r_crc <= n_crc;
            if (pos == POS_CRC_LOW) begin
                r_crc_low <= i_word.rx_byte;
            end
        end
    end

    // Payload bytes shift in from the top, so after eighteen of them the
    // first payload byte sits at index zero.
    always_ff @(posedge i_clk) begin
        if (i_accept && pos >= POS_PAYLOAD0 && pos < POS_CRC_LOW) begin
            r_pend <= {i_word.rx_byte, r_pend[PAYLOAD_LEN-1:1]};
        end
    end

endmodule

// ===== hdl/crc16cfr_fifo.sv =====
`timescale 1ns / 1ps
// ============================================================================
// CRC-16 checked frame receiver frame queue
// Short queue of finished frames between the front and the back end.
// ============================================================================
module crc16cfr_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  crc16cfr_pkg::t_frame_rec i_rec,
    input  logic                     i_pop,
    output crc16cfr_pkg::t_frame_rec o_rec,
    output crc16cfr_pkg::t_q_stat    o_stat
);
    import crc16cfr_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_frame_rec       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    always_comb begin
        o_stat.full  = (r_count == CNT_W'(DEPTH));
        o_stat.empty = (r_count == '0);
        do_push = i_push && !o_stat.full;
        do_pop  = i_pop && !o_stat.empty;
        o_rec   = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

// ===== hdl/crc16cfr_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// CRC-16 checked frame receiver back end
// Updates the accepted payload on good frames and holds the result word.
// ============================================================================
module crc16cfr_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  crc16cfr_pkg::t_frame_rec i_rec,
    input  crc16cfr_pkg::t_q_stat    i_q_stat,
    output logic                     o_q_pop,
    input  logic                     i_pop,
    output logic                     o_empty,
    output crc16cfr_pkg::t_out_word  o_word
);
    import crc16cfr_pkg::*;

    t_payload  r_acc, n_acc;
    logic      r_valid;
    t_out_word r_out, n_out;

    always_comb begin
        o_q_pop = !i_q_stat.empty && (!r_valid || i_pop);
        n_acc   = i_rec.ok ? i_rec.payload : r_acc;

        n_out.frame_ok        = i_rec.ok;
        n_out.left_switch     = n_acc[0];
        n_out.right_switch    = n_acc[1];
        n_out.left_stick_x    = $signed({n_acc[3], n_acc[2]});
        n_out.left_stick_y    = $signed({n_acc[5], n_acc[4]});
        n_out.right_stick_x   = $signed({n_acc[7], n_acc[6]});
        n_out.right_stick_y   = $signed({n_acc[9], n_acc[8]});
        n_out.zero_force_flag = n_acc[10];
        n_out.angle_bits      = {n_acc[14], n_acc[13], n_acc[12], n_acc[11]};
        n_out.motion_select   = n_acc[15];
        n_out.mine_select     = n_acc[16];
        n_out.pose_select     = n_acc[17];

        o_empty = !r_valid;
        o_word  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_acc   <= ACC_RESET;
        end else begin
            if (o_q_pop) begin
                r_valid <= 1'b1;
                r_acc   <= n_acc;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== hdl/crc16_checked_frame_receiver.sv =====
`timescale 1ns / 1ps
// ============================================================================
// CRC-16 checked frame receiver
// Deframes 22-byte frames, checks the CRC-16 and reports the accepted payload.
// ============================================================================
// Throughput: one byte word per cycle, sustained, while the frame queue has room.
// On its last byte a frame is queued, then loaded into the free output register.
// The rate is set by the combinational, eight-step CRC update in the front end.
// Reset is synchronous, active low; it clears position, CRC, queue and result,
// and loads the accepted payload with zeros and the motion and mine bytes at one.
module crc16_checked_frame_receiver #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  crc16cfr_pkg::t_in_word  i_in_word,
    output logic                    empty,
    input  logic                    pop,
    output crc16cfr_pkg::t_out_word o_out_word
);
    import crc16cfr_pkg::*;

    logic       accept;
    logic       rec_push;
    t_frame_rec front_rec;
    t_frame_rec queue_rec;
    t_q_stat    q_stat;
    logic       q_pop;

    // The input side stalls only when the frame queue is full. Most bytes
    // would never need a slot, but holding them all keeps the position
    // counter simple and a frame-end byte never finds the queue without room.
    assign full   = q_stat.full;
    assign accept = push && !full;

    // The front end follows the byte position in the frame, runs the CRC
    // over the payload bytes and captures them, and on the last byte of a
    // frame pushes one record with the check result into the queue.
    crc16cfr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_word     (i_in_word),
        .o_rec_push (rec_push),
        .o_rec      (front_rec)
    );

    // A short queue lets the back end stall on the result side while bytes
    // of the next frame keep arriving.
    crc16cfr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_rec   (front_rec),
        .i_pop   (q_pop),
        .o_rec   (queue_rec),
        .o_stat  (q_stat)
    );

    // The back end latches the payload of good frames into the accepted set
    // and builds the result word in its output register.
    crc16cfr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rec    (queue_rec),
        .i_q_stat (q_stat),
        .o_q_pop  (q_pop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_word   (o_out_word)
    );

`ifndef SYNTHESIS
    // A finished frame is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rec_push |-> !q_stat.full)
        else $error("frame record pushed into a full queue");

    // Reset leaves no result word waiting.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result word present after reset");

    // A queued frame moves into an empty output register in the next cycle.
    a_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!q_stat.empty && empty) |=> !empty)
        else $error("queued frame did not reach the output register");
`endif

endmodule
